// ===== src/thlr_pkg.sv =====
// Shared types and constants for the thick line rasterizer core.
// Depends on nothing; used by thick_line_rasterizer_core.
`default_nettype none

package thlr_pkg;

  // Default parameter values.
  localparam int COORD_BITS_DEF    = 12;
  localparam int MAX_THICKNESS_DEF = 7;

  // Field widths fixed by the register map and the memory format.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int DIM_W      = 12;
  localparam int PITCH_W    = 14;
  localparam int CHAN_W     = 3;
  localparam int THICK_W    = 3;
  localparam int OFF_W      = 3;
  localparam int ADDR_W     = 24;
  localparam int COLOUR_W   = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS     = 3'd4;

  // Register reset values.
  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH   = 12'd1024;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT  = 12'd1024;
  localparam logic [PITCH_W-1:0] RST_ROW_PITCH     = 14'd4096;
  localparam logic [CHAN_W-1:0]  RST_CHANNEL_COUNT = 3'd4;
  localparam logic [THICK_W-1:0] RST_THICKNESS     = 3'd3;

  // Pixel format: four bytes per pixel, at most three colour bytes, alpha in byte 3.
  localparam logic [CHAN_W-1:0]   BYTES_PER_PIXEL = 3'd4;
  localparam logic [COLOUR_W-1:0] MAX_COLOUR      = 2'd3;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAMP,
    ST_NOLINE
  } thlr_state_t;

endpackage

`default_nettype wire

// ===== src/thick_line_rasterizer_core.sv =====
// Thick line rasterizer: Bresenham walker that stamps a square brush per step.
// Depends on thlr_pkg for constants, register indexes and the state type.
`default_nettype none

// Channel   Handshake              Direction  Payload
// in_       in_valid / in_stall    input      req_type, start_x, start_y, end_x, end_y
// out_      out_valid / out_stall  output     pixel_x/y, byte_address, enables, flags
// cfg_      cfg_valid / cfg_ready  input      cfg_index, cfg_data
//
// A start transfer gives no result. A step transfer with a line active gives (2*h+1)^2
// results (h = thickness/2): after the accept, one brush position per cycle, while the
// output does not stall, through the shared clip and address unit, which is the limit.
// The default thickness 3 gives h = 1. A step with no line gives one idle result.
// Reset is synchronous and active low; it restores the register defaults and drops
// any line. A stall on the output holds the result register and freezes the walk.

module thick_line_rasterizer_core #(
  parameter int COORD_BITS    = thlr_pkg::COORD_BITS_DEF,
  parameter int MAX_THICKNESS = thlr_pkg::MAX_THICKNESS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Configuration writes.
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [thlr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [thlr_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Requests.
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   in_req_type,
  input  wire  signed [COORD_BITS-1:0]          in_start_x,
  input  wire  signed [COORD_BITS-1:0]          in_start_y,
  input  wire  signed [COORD_BITS-1:0]          in_end_x,
  input  wire  signed [COORD_BITS-1:0]          in_end_y,
  // Brush positions.
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [COORD_BITS:0]            out_pixel_x,
  output logic signed [COORD_BITS:0]            out_pixel_y,
  output logic [thlr_pkg::ADDR_W-1:0]           out_byte_address,
  output logic                                  out_write_enable,
  output logic [thlr_pkg::COLOUR_W-1:0]         out_colour_channels,
  output logic                                  out_write_alpha,
  output logic                                  out_last_of_step,
  output logic                                  out_line_done
);

  // Pixel coordinate width, the width used for clip compares, and the delta and
  // error widths of the walker.
  localparam int PW     = COORD_BITS + 1;
  localparam int CW     = ((PW > thlr_pkg::DIM_W) ? PW : thlr_pkg::DIM_W) + 1;
  localparam int DW     = COORD_BITS + 1;
  localparam int EW     = COORD_BITS + 3;
  localparam int PROD_W = CW + thlr_pkg::PITCH_W;
  localparam logic [thlr_pkg::THICK_W-1:0] THICK_MAX = thlr_pkg::THICK_W'(MAX_THICKNESS);

  // Configuration registers.
  logic [thlr_pkg::DIM_W-1:0]   cfg_width_r;
  logic [thlr_pkg::DIM_W-1:0]   cfg_height_r;
  logic [thlr_pkg::PITCH_W-1:0] cfg_pitch_r;
  logic [thlr_pkg::CHAN_W-1:0]  cfg_chan_r;
  logic [thlr_pkg::THICK_W-1:0] cfg_thick_r;

  // Walker state.
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [DW-1:0]                delta_x_r, delta_y_r;
  logic                         step_x_neg_r, step_y_neg_r;
  logic signed [EW-1:0]         err_r;
  logic                         line_active_r;

  // Sequencer state: brush offsets, half width and end-point flag of this step.
  thlr_pkg::thlr_state_t        state_r, state_nxt;
  logic signed [thlr_pkg::OFF_W-1:0] ox_r, oy_r;
  logic [1:0]                   h_r;
  logic                         done_r;

  // Result register.
  logic                         out_valid_r;

  // Sequencer controls.
  logic in_accept, out_free, emit_stamp, emit_idle, last_pos;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Start arithmetic: absolute deltas, step directions and initial error.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] diff_x, diff_y;
  logic [DW-1:0]        abs_x, abs_y;
  logic signed [EW-1:0] err_start;

  always_comb begin
    diff_x    = PW'(in_end_x) - PW'(in_start_x);
    diff_y    = PW'(in_end_y) - PW'(in_start_y);
    abs_x     = diff_x[PW-1] ? DW'(-diff_x) : DW'(diff_x);
    abs_y     = diff_y[PW-1] ? DW'(-diff_y) : DW'(diff_y);
    err_start = $signed(EW'(abs_x)) - $signed(EW'(abs_y));
  end

  // Brush half width from the saturated thickness.
  logic [thlr_pkg::THICK_W-1:0]      thick_sat;
  logic signed [thlr_pkg::OFF_W-1:0] h_s;

  always_comb begin
    thick_sat = (cfg_thick_r > THICK_MAX) ? THICK_MAX : cfg_thick_r;
    h_s       = $signed({1'b0, h_r});
  end

  // ---------------------------------------------------------------------------
  // Shared position unit: brush position, clip test and byte address.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] px, py;
  logic [CW-1:0]        px_u, py_u;
  logic                 in_image;
  logic [PROD_W-1:0]    addr_full;
  logic [thlr_pkg::COLOUR_W-1:0] colours;
  logic                 alpha;

  always_comb begin
    px       = PW'(cur_x_r) + PW'(ox_r);
    py       = PW'(cur_y_r) + PW'(oy_r);
    px_u     = CW'($unsigned(px));
    py_u     = CW'($unsigned(py));
    in_image = !px[PW-1] && !py[PW-1] &&
               (px_u < CW'(cfg_width_r)) && (py_u < CW'(cfg_height_r));
    addr_full = PROD_W'(py_u) * PROD_W'(cfg_pitch_r) + (PROD_W'(px_u) << 2);
    colours = (cfg_chan_r < 3'(thlr_pkg::MAX_COLOUR)) ? cfg_chan_r[1:0]
                                                       : thlr_pkg::MAX_COLOUR;
    alpha   = (cfg_chan_r >= thlr_pkg::BYTES_PER_PIXEL);
    last_pos = (ox_r == h_s) && (oy_r == h_s);
  end

  // ---------------------------------------------------------------------------
  // Bresenham advance, applied with the final brush position of a step.
  // ---------------------------------------------------------------------------
  logic signed [EW:0]   e2, dx_s, dy_s, err_sum;
  logic                 move_x, move_y;

  always_comb begin
    e2      = $signed({err_r, 1'b0});
    dx_s    = $signed((EW + 1)'(delta_x_r));
    dy_s    = $signed((EW + 1)'(delta_y_r));
    move_x  = e2 > -dy_s;
    move_y  = e2 < dx_s;
    err_sum = (EW + 1)'(err_r) - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      thlr_pkg::ST_IDLE: begin
        if (in_accept && in_req_type == thlr_pkg::REQ_STEP) begin
          state_nxt = line_active_r ? thlr_pkg::ST_STAMP : thlr_pkg::ST_NOLINE;
        end
      end
      thlr_pkg::ST_STAMP: begin
        if (out_free && last_pos) begin
          state_nxt = thlr_pkg::ST_IDLE;
        end
      end
      thlr_pkg::ST_NOLINE: begin
        if (out_free) begin
          state_nxt = thlr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = thlr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall   = 1'b1;
    emit_stamp = 1'b0;
    emit_idle  = 1'b0;
    unique case (state_r)
      thlr_pkg::ST_IDLE:   in_stall   = 1'b0;
      thlr_pkg::ST_STAMP:  emit_stamp = out_free;
      thlr_pkg::ST_NOLINE: emit_idle  = out_free;
      default:             in_stall   = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= thlr_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      line_active_r <= 1'b0;
      cfg_width_r   <= thlr_pkg::RST_IMAGE_WIDTH;
      cfg_height_r  <= thlr_pkg::RST_IMAGE_HEIGHT;
      cfg_pitch_r   <= thlr_pkg::RST_ROW_PITCH;
      cfg_chan_r    <= thlr_pkg::RST_CHANNEL_COUNT;
      cfg_thick_r   <= thlr_pkg::RST_THICKNESS;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      goal_x_r      <= '0;
      goal_y_r      <= '0;
      delta_x_r     <= '0;
      delta_y_r     <= '0;
      step_x_neg_r  <= 1'b0;
      step_y_neg_r  <= 1'b0;
      err_r         <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          thlr_pkg::CFG_IMAGE_WIDTH:   cfg_width_r  <= cfg_data[thlr_pkg::DIM_W-1:0];
          thlr_pkg::CFG_IMAGE_HEIGHT:  cfg_height_r <= cfg_data[thlr_pkg::DIM_W-1:0];
          thlr_pkg::CFG_ROW_PITCH:     cfg_pitch_r  <= cfg_data[thlr_pkg::PITCH_W-1:0];
          thlr_pkg::CFG_CHANNEL_COUNT: cfg_chan_r   <= cfg_data[thlr_pkg::CHAN_W-1:0];
          thlr_pkg::CFG_THICKNESS:     cfg_thick_r  <= cfg_data[thlr_pkg::THICK_W-1:0];
          default: ;
        endcase
      end

      // A start replaces any line in progress.
      if (in_accept && in_req_type == thlr_pkg::REQ_START) begin
        cur_x_r       <= in_start_x;
        cur_y_r       <= in_start_y;
        goal_x_r      <= in_end_x;
        goal_y_r      <= in_end_y;
        delta_x_r     <= abs_x;
        delta_y_r     <= abs_y;
        step_x_neg_r  <= !(in_start_x < in_end_x);
        step_y_neg_r  <= !(in_start_y < in_end_y);
        err_r         <= err_start;
        line_active_r <= 1'b1;
      end

      // After the final position the line either ends or takes one step.
      if (emit_stamp && last_pos) begin
        if (done_r) begin
          line_active_r <= 1'b0;
        end else begin
          err_r <= EW'(err_sum);
          if (move_x) begin
            cur_x_r <= step_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
          end
          if (move_y) begin
            cur_y_r <= step_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
          end
        end
      end

      if (emit_stamp || emit_idle) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Brush walk counters and the end-point flag; no reset needed.
  always_ff @(posedge clk) begin
    if (in_accept && in_req_type == thlr_pkg::REQ_STEP) begin
      h_r    <= thick_sat[2:1];
      ox_r   <= -$signed({1'b0, thick_sat[2:1]});
      oy_r   <= -$signed({1'b0, thick_sat[2:1]});
      done_r <= (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);
    end else if (emit_stamp) begin
      if (ox_r == h_s) begin
        ox_r <= -h_s;
        oy_r <= oy_r + 1'b1;
      end else begin
        ox_r <= ox_r + 1'b1;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit_stamp) begin
      out_pixel_x         <= px;
      out_pixel_y         <= py;
      out_byte_address    <= in_image ? addr_full[thlr_pkg::ADDR_W-1:0] : '0;
      out_write_enable    <= in_image;
      out_colour_channels <= in_image ? colours : '0;
      out_write_alpha     <= in_image && alpha;
      out_last_of_step    <= last_pos;
      out_line_done       <= done_r;
    end else if (emit_idle) begin
      out_pixel_x         <= '0;
      out_pixel_y         <= '0;
      out_byte_address    <= '0;
      out_write_enable    <= 1'b0;
      out_colour_channels <= '0;
      out_write_alpha     <= 1'b0;
      out_last_of_step    <= 1'b0;
      out_line_done       <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_offsets_in_brush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == thlr_pkg::ST_STAMP) |->
      (ox_r >= -h_s && ox_r <= h_s && oy_r >= -h_s && oy_r <= h_s))
    else $error("brush offset outside the brush");

  a_start_arms_line: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_req_type == thlr_pkg::REQ_START) |=>
      (line_active_r && state_r == thlr_pkg::ST_IDLE))
    else $error("start transfer did not arm the line");

  a_line_ends_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(line_active_r) && $past(rst_n)) |->
      $past(state_r == thlr_pkg::ST_STAMP && done_r))
    else $error("line dropped outside the end-point step");

  a_noline_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == thlr_pkg::ST_NOLINE) |-> !line_active_r)
    else $error("idle result issued while a line is active");

endmodule

`default_nettype wire
